@@ rtl/sfir_pkg.sv @@
package sfir_pkg;

    // Q3.15 coefficients: product carries 15 fraction bits
    localparam int FRAC_BITS = 15;

    // half_length register and coef_index field
    localparam int HL_W = 5;
    localparam logic [HL_W-1:0] HL_RESET = 5'd31;

    // tuser codes on the input side
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    // one tap step travelling alongside the memory read data
    typedef struct packed {
        logic valid;   // step carries a tap
        logic first;   // centre tap, restarts the accumulator
        logic last;    // final tap of the sample
        logic a_ok;    // inner sample written since reset
        logic b_ok;    // outer sample written since reset
        logic c_ok;    // coefficient written since reset
    } t_tap_ctl;

endpackage

@@ rtl/symmetric_fir_filter.sv @@
// Odd-length linear-phase FIR filter holding only half of its impulse
// response. Input transactions carry a mode in s_axis_tuser: a coefficient
// load (tuser 1) writes coef_value at coef_index and returns
// nothing; indexes at or above MAX_HALF_TAPS are dropped. A sample
// (tuser 0) is pushed into the delay line and yields one output
// transaction: h0 times the centre sample plus every symmetric pair times
// its coefficient, rounded half up from Q3.15 and clipped to SAMPLE_WIDTH
// bits, with m_axis_tuser flagging a clip. Let n be half_length (clamped to
// MAX_HALF_TAPS-1): the sample is written at the accepting edge, then
// n + 1 tap steps issue one tap pair per cycle through the two-read-port
// delay memory and the single shared multiplier, followed by the product,
// accumulate, round-and-clip and output register stages. The next
// transaction is taken once the result moves into the output register. A
// result waiting in the output register does not hold off the input, but a
// finished result that cannot move into it does. half_length is to be
// written through i_cfg_wr_en / i_cfg_wr_data only while the filter is idle;
// the block itself does not enforce this. Delay line and coefficients read
// as zero after reset until written; no clearing pass is needed.
module symmetric_fir_filter
    import sfir_pkg::*;
#(
    parameter int MAX_HALF_TAPS = 32,
    parameter int SAMPLE_WIDTH  = 16,
    parameter int COEF_WIDTH    = 18
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // configuration: half_length
    input  logic                         i_cfg_wr_en,
    input  logic [HL_W-1:0]              i_cfg_wr_data,

    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [sample | coef_index | coef_value | zero pad], lowest bits first
    input  logic [((SAMPLE_WIDTH+HL_W+COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic                         s_axis_tuser,

    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [filtered | zero pad], lowest bits first
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // saturated
    output logic                         m_axis_tuser
);

    localparam int DEPTH    = 2 * MAX_HALF_TAPS - 1;     // delay line entries
    localparam int AW       = $clog2(DEPTH);             // delay memory address
    localparam int NW       = $clog2(MAX_HALF_TAPS);     // tap index
    localparam int FW       = $clog2(DEPTH + 1);         // fill count
    localparam int GW       = NW + 1;                    // sample age, up to 2n
    localparam int DW       = ((AW > GW) ? AW : GW) + 1; // signed address math
    localparam int CMPW     = (FW > GW) ? FW : GW;
    localparam int OUT_W    = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int ACC_FULL = SAMPLE_WIDTH + COEF_WIDTH + NW + 2;
    localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;

    localparam logic [1:0] ST_IDLE  = 2'd0;  // take transactions
    localparam logic [1:0] ST_RUN   = 2'd1;  // issue one tap pair per cycle
    localparam logic [1:0] ST_DRAIN = 2'd2;  // wait for the MAC result

    // delay line: circular buffer, newest sample at r_newest
    logic [SAMPLE_WIDTH-1:0]  r_line [DEPTH];
    logic [COEF_WIDTH-1:0]    r_coef [MAX_HALF_TAPS];
    logic [MAX_HALF_TAPS-1:0] r_coef_vld;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    logic [HL_W-1:0]          r_half_length;
    logic [AW-1:0]            r_wp;
    logic [AW-1:0]            r_newest;
    logic [FW-1:0]            r_fill;
    logic [NW-1:0]            r_n;
    logic [NW-1:0]            r_i;

    logic [SAMPLE_WIDTH-1:0]  w_sample;
    logic [HL_W-1:0]          w_coef_index;
    logic [COEF_WIDTH-1:0]    w_coef_value;
    logic                     w_in_take;
    logic [NW-1:0]            w_n_clamp;

    logic [GW-1:0]            w_age_a;
    logic [GW-1:0]            w_age_b;
    logic [AW-1:0]            w_addr_a;
    logic [AW-1:0]            w_addr_b;
    t_tap_ctl                 w_ctl;

    logic [SAMPLE_WIDTH-1:0]  r_da;
    logic [SAMPLE_WIDTH-1:0]  r_db;
    logic [COEF_WIDTH-1:0]    r_cq;
    t_tap_ctl                 r_ctl;

    logic                     w_res_valid;
    logic [SAMPLE_WIDTH-1:0]  w_res_filtered;
    logic                     w_res_saturated;
    logic                     w_res_take;

    logic                     r_out_valid;
    logic [SAMPLE_WIDTH-1:0]  r_out_filtered;
    logic                     r_out_sat;

    // address of the sample 'age' places behind the newest one
    function automatic logic [AW-1:0] f_age_addr(input logic [AW-1:0] newest,
                                                 input logic [GW-1:0] age);
        logic [DW-1:0] t;
        t = DW'(newest) - DW'(age);
        if (t[DW-1]) begin
            t = t + DW'(DEPTH);
        end
        return t[AW-1:0];
    endfunction

    assign w_sample     = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign w_coef_index = s_axis_tdata[SAMPLE_WIDTH +: HL_W];
    assign w_coef_value = s_axis_tdata[SAMPLE_WIDTH+HL_W +: COEF_WIDTH];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    // lengths beyond the store use the longest filter available
    assign w_n_clamp = (32'(r_half_length) > 32'(MAX_HALF_TAPS - 1))
                     ? NW'(MAX_HALF_TAPS - 1) : NW'(r_half_length);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_length <= HL_RESET;
        end else if (i_cfg_wr_en) begin
            r_half_length <= i_cfg_wr_data;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_take && s_axis_tuser == MODE_SAMPLE) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_i == r_n) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_take && s_axis_tuser == MODE_SAMPLE) begin
                r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + AW'(1);
                if (32'(r_fill) != DEPTH) begin
                    r_fill <= r_fill + FW'(1);
                end
                r_i <= '0;
            end else if (r_state == ST_RUN) begin
                r_i <= r_i + NW'(1);
            end
        end
        if (w_in_take && s_axis_tuser == MODE_SAMPLE) begin
            r_newest <= r_wp;
            r_n      <= w_n_clamp;
        end
    end

    // ---------------- tap issue ----------------
    always_comb begin
        w_age_a   = GW'(r_n) - GW'(r_i);
        w_age_b   = GW'(r_n) + GW'(r_i);
        w_addr_a  = f_age_addr(r_newest, w_age_a);
        w_addr_b  = f_age_addr(r_newest, w_age_b);
        w_ctl.valid = (r_state == ST_RUN);
        w_ctl.first = (r_i == '0);
        w_ctl.last  = (r_i == r_n);
        // a sample is real only if it was pushed since reset
        w_ctl.a_ok  = CMPW'(w_age_a) < CMPW'(r_fill);
        w_ctl.b_ok  = CMPW'(w_age_b) < CMPW'(r_fill);
        w_ctl.c_ok  = r_coef_vld[r_i];
    end

    // delay memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_in_take && s_axis_tuser == MODE_SAMPLE) begin
            r_line[r_wp] <= w_sample;
        end
        r_da <= r_line[w_addr_a];
        r_db <= r_line[w_addr_b];
    end

    // coefficient memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_in_take && s_axis_tuser == MODE_LOAD
                && 32'(w_coef_index) < 32'(MAX_HALF_TAPS)) begin
            r_coef[NW'(w_coef_index)] <= w_coef_value;
        end
        r_cq <= r_coef[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
        end else if (w_in_take && s_axis_tuser == MODE_LOAD
                && 32'(w_coef_index) < 32'(MAX_HALF_TAPS)) begin
            r_coef_vld[NW'(w_coef_index)] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= w_ctl;
        end
    end

    // ---------------- multiply-accumulate ----------------
    sfir_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .ACC_W        (ACC_W)
    ) u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (r_ctl),
        .i_da         (r_da),
        .i_db         (r_db),
        .i_coef       (r_cq),
        .i_take       (w_res_take),
        .o_res_valid  (w_res_valid),
        .o_filtered   (w_res_filtered),
        .o_saturated  (w_res_saturated)
    );

    // ---------------- output register ----------------
    assign w_res_take = w_res_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_take) begin
            r_out_filtered <= w_res_filtered;
            r_out_sat      <= w_res_saturated;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_filtered);
    assign m_axis_tuser  = r_out_sat;

    // ---------------- assertions ----------------
    a_res_only_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (r_state == ST_DRAIN))
        else $error("MAC result outside drain state");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= DEPTH)
        else $error("delay line fill count overran");

    a_tap_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_i <= r_n))
        else $error("tap index ran past half length");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> $stable(r_out_filtered))
        else $error("pending result overwritten");

    a_issue_last_then_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.valid && w_ctl.last) |=> (r_state == ST_DRAIN))
        else $error("tap walk did not end in drain");

endmodule

@@ rtl/sfir_mac.sv @@
module sfir_mac
    import sfir_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18,
    parameter int ACC_W        = 41
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_tap_ctl                i_ctl,
    input  logic [SAMPLE_WIDTH-1:0] i_da,
    input  logic [SAMPLE_WIDTH-1:0] i_db,
    input  logic [COEF_WIDTH-1:0]   i_coef,
    input  logic                    i_take,
    output logic                    o_res_valid,
    output logic [SAMPLE_WIDTH-1:0] o_filtered,
    output logic                    o_saturated
);

    localparam int PAIR_W = SAMPLE_WIDTH + 1;
    localparam int PROD_W = PAIR_W + COEF_WIDTH;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));

    logic signed [PAIR_W-1:0]       w_a;
    logic signed [PAIR_W-1:0]       w_b;
    logic signed [PAIR_W-1:0]       w_pair;
    logic signed [COEF_WIDTH-1:0]   w_coef;

    logic signed [PROD_W-1:0]       r_prod;
    logic                           r_p_valid;
    logic                           r_p_first;
    logic                           r_p_last;

    logic signed [ACC_W-1:0]        w_prod_ext;
    logic signed [ACC_W-1:0]        r_acc;
    logic                           r_acc_done;

    logic signed [ACC_W-1:0]        w_rnd;
    logic signed [ACC_W-1:0]        w_shift;
    logic                           w_fits;
    logic [SAMPLE_WIDTH-1:0]        w_clip;

    logic                           r_res_valid;
    logic [SAMPLE_WIDTH-1:0]        r_filtered;
    logic                           r_saturated;

    // pair add and coefficient select; unwritten entries read as zero
    always_comb begin
        w_a    = i_ctl.a_ok ? PAIR_W'($signed(i_da)) : '0;
        w_b    = (i_ctl.b_ok && !i_ctl.first) ? PAIR_W'($signed(i_db)) : '0;
        w_pair = w_a + w_b;
        w_coef = i_ctl.c_ok ? $signed(i_coef) : '0;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_pair * w_coef;
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_ctl.valid;
        end
        r_p_first <= i_ctl.first;
        r_p_last  <= i_ctl.last;
    end

    // wraps modulo 2^ACC_W when ACC_W is capped at 64
    assign w_prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_done <= 1'b0;
        end else begin
            r_acc_done <= r_p_valid && r_p_last;
        end
        if (r_p_valid) begin
            r_acc <= r_p_first ? w_prod_ext : r_acc + w_prod_ext;
        end
    end

    // round half up, then clip to the sample range
    always_comb begin
        w_rnd   = r_acc + RND_HALF;
        w_shift = w_rnd >>> FRAC_BITS;
        w_fits  = (&w_shift[ACC_W-1:SAMPLE_WIDTH-1]) || !(|w_shift[ACC_W-1:SAMPLE_WIDTH-1]);
        w_clip  = w_shift[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                   : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (r_acc_done) begin
            r_res_valid <= 1'b1;
        end else if (i_take) begin
            r_res_valid <= 1'b0;
        end
        if (r_acc_done) begin
            r_filtered  <= w_fits ? w_shift[SAMPLE_WIDTH-1:0] : w_clip;
            r_saturated <= !w_fits;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_filtered  = r_filtered;
    assign o_saturated = r_saturated;

endmodule
